// File: src/gbts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and codes for the gap buffer text store: request and response
// beats, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gbts_pkg;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] position;
        logic [7:0] char_in;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] char_out;
        logic [7:0] char_count;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MOVE,
        S_EDIT,
        S_RESP
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch request and its status
        logic step;       // one gap move step
        logic edit;       // insert write or remove read
        logic rd_issue;   // issue a read for a read request
        logic post;       // register the response beat
        logic post_rdata; // response byte comes from a store
    } gbts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reject;
        logic is_read;
        logic is_insert;
        logic at_target;
    } gbts_stat_t;

endpackage
`default_nettype wire

// File: src/gbts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/gbts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_ctrl
// Request sequencer: checks, moves the gap step by step, applies the edit or
// read and posts one response beat per request.
// ----------------------------------------------------------------------------
module gbts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire gbts_pkg::gbts_stat_t stat,
    output      gbts_pkg::gbts_cmd_t  cmd
);

    gbts_pkg::ctrl_state_t state_reg;
    gbts_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            gbts_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = gbts_pkg::S_CHECK;
                end
            end
            gbts_pkg::S_CHECK:
            begin
                if (stat.reject)
                begin
                    cmd.post   = 1'b1;
                    state_next = gbts_pkg::S_IDLE;
                end
                else if (stat.is_read)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = gbts_pkg::S_RESP;
                end
                else
                begin
                    state_next = gbts_pkg::S_MOVE;
                end
            end
            gbts_pkg::S_MOVE:
            begin
                cmd.step = 1'b1;
                if (stat.at_target)
                begin
                    state_next = gbts_pkg::S_EDIT;
                end
            end
            gbts_pkg::S_EDIT:
            begin
                cmd.edit = 1'b1;
                if (stat.is_insert)
                begin
                    cmd.post   = 1'b1;
                    state_next = gbts_pkg::S_IDLE;
                end
                else
                begin
                    state_next = gbts_pkg::S_RESP;
                end
            end
            gbts_pkg::S_RESP:
            begin
                cmd.post       = 1'b1;
                cmd.post_rdata = 1'b1;
                state_next     = gbts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gbts_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/gbts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_datapath
// Left and right stores, gap counters, request registers and response
// register. One gap step per cycle, with the store write trailing its read.
// ----------------------------------------------------------------------------
module gbts_datapath #(
    parameter int CAPACITY = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gbts_pkg::req_t      req,
    input  wire gbts_pkg::gbts_cmd_t cmd,
    output      gbts_pkg::gbts_stat_t stat,
    output      logic                done,
    output      gbts_pkg::rsp_t      rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CMP_W  = ((ADDR_W > 8) ? ADDR_W : 8) + 1;
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(CAPACITY - 1);

    // request and gap state
    gbts_pkg::req_t    req_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [ADDR_W-1:0] lc_reg;
    logic [ADDR_W-1:0] lc_next;
    logic [ADDR_W-1:0] rc_reg;
    logic [ADDR_W-1:0] rc_next;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] len_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic              pend_right_reg;
    logic              pend_right_next;
    logic              src_left_reg;
    logic              src_left_next;
    logic              done_reg;
    gbts_pkg::rsp_t    rsp_reg;

    // store ports
    logic              l_we;
    logic [ADDR_W-1:0] l_waddr;
    logic [7:0]        l_wdata;
    logic              l_re;
    logic [ADDR_W-1:0] l_raddr;
    logic [7:0]        l_rdata;
    logic              r_we;
    logic [ADDR_W-1:0] r_waddr;
    logic [7:0]        r_wdata;
    logic              r_re;
    logic [ADDR_W-1:0] r_raddr;
    logic [7:0]        r_rdata;

    // wide compare views
    logic [CMP_W-1:0]  in_pos_w;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  len_w;
    logic [CMP_W-1:0]  lc_w;
    logic [CMP_W-1:0]  len_next_w;
    logic [CMP_W-1:0]  target_w;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] rd_right_addr;

    assign in_pos_w      = CMP_W'(req.position);
    assign pos_w         = CMP_W'(req_reg.position);
    assign len_w         = CMP_W'(len_reg);
    assign lc_w          = CMP_W'(lc_reg);
    assign len_next_w    = CMP_W'(len_next);
    assign target_w      = (req_reg.kind == gbts_pkg::KIND_INSERT) ? pos_w : pos_w + 1'b1;
    assign target        = target_w[ADDR_W-1:0];
    assign rd_right_addr = len_reg - 1'b1 - pos_w[ADDR_W-1:0];

    // request status against the current length
    always_comb
    begin
        status_next = gbts_pkg::ST_OK;
        case (req.kind)
            gbts_pkg::KIND_INSERT:
            begin
                if (len_w >= LEN_MAX)
                begin
                    status_next = gbts_pkg::ST_FULL;
                end
                else if (in_pos_w > len_w)
                begin
                    status_next = gbts_pkg::ST_RANGE;
                end
            end
            gbts_pkg::KIND_REMOVE:
            begin
                if (len_reg == '0)
                begin
                    status_next = gbts_pkg::ST_EMPTY;
                end
                else if (in_pos_w >= len_w)
                begin
                    status_next = gbts_pkg::ST_RANGE;
                end
            end
            gbts_pkg::KIND_READ:
            begin
                if (in_pos_w >= len_w)
                begin
                    status_next = gbts_pkg::ST_RANGE;
                end
            end
            default:
            begin
                status_next = gbts_pkg::ST_RANGE;
            end
        endcase
    end

    // status to the controller
    always_comb
    begin
        stat.reject    = (status_reg != gbts_pkg::ST_OK);
        stat.is_read   = (req_reg.kind == gbts_pkg::KIND_READ);
        stat.is_insert = (req_reg.kind == gbts_pkg::KIND_INSERT);
        stat.at_target = (lc_reg == target);
    end

    // gap moves, edits and store accesses
    always_comb
    begin
        lc_next         = lc_reg;
        rc_next         = rc_reg;
        len_next        = len_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_right_next = pend_right_reg;
        src_left_next   = src_left_reg;
        l_we    = 1'b0;
        l_waddr = pend_addr_reg;
        l_wdata = r_rdata;
        l_re    = 1'b0;
        l_raddr = lc_reg - 1'b1;
        r_we    = 1'b0;
        r_waddr = pend_addr_reg;
        r_wdata = l_rdata;
        r_re    = 1'b0;
        r_raddr = rc_reg - 1'b1;
        if (cmd.step)
        begin
            // finish the previous step's write
            if (pend_reg)
            begin
                if (pend_right_reg)
                begin
                    r_we = 1'b1;
                end
                else
                begin
                    l_we = 1'b1;
                end
            end
            // start the next step
            if (lc_reg != target)
            begin
                pend_next = 1'b1;
                if (lc_reg > target)
                begin
                    l_re            = 1'b1;
                    pend_addr_next  = rc_reg;
                    pend_right_next = 1'b1;
                    lc_next         = lc_reg - 1'b1;
                    rc_next         = rc_reg + 1'b1;
                end
                else
                begin
                    r_re            = 1'b1;
                    pend_addr_next  = lc_reg;
                    pend_right_next = 1'b0;
                    lc_next         = lc_reg + 1'b1;
                    rc_next         = rc_reg - 1'b1;
                end
            end
        end
        else if (cmd.edit)
        begin
            if (req_reg.kind == gbts_pkg::KIND_INSERT)
            begin
                l_we     = 1'b1;
                l_waddr  = lc_reg;
                l_wdata  = req_reg.char_in;
                lc_next  = lc_reg + 1'b1;
                len_next = len_reg + 1'b1;
            end
            else
            begin
                l_re          = 1'b1;
                src_left_next = 1'b1;
                lc_next       = lc_reg - 1'b1;
                len_next      = len_reg - 1'b1;
            end
        end
        else if (cmd.rd_issue)
        begin
            if (pos_w < lc_w)
            begin
                l_re          = 1'b1;
                l_raddr       = pos_w[ADDR_W-1:0];
                src_left_next = 1'b1;
            end
            else
            begin
                r_re          = 1'b1;
                r_raddr       = rd_right_addr;
                src_left_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg   <= '0;
            rc_reg   <= '0;
            len_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            lc_reg   <= lc_next;
            rc_reg   <= rc_next;
            len_reg  <= len_next;
            pend_reg <= pend_next;
            done_reg <= cmd.post;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        pend_right_reg <= pend_right_next;
        src_left_reg   <= src_left_next;
        if (cmd.load)
        begin
            req_reg    <= req;
            status_reg <= status_next;
        end
        if (cmd.post)
        begin
            rsp_reg.status     <= status_reg;
            rsp_reg.char_out   <= !cmd.post_rdata ? 8'd0 :
                                  (src_left_reg ? l_rdata : r_rdata);
            rsp_reg.char_count <= len_next_w[7:0];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // left store: text before the gap
    gbts_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_left_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // right store: text after the gap, top entry first
    gbts_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_right_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

endmodule
`default_nettype wire

// File: src/gap_buffer_text_store_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Byte text store kept as a gap buffer in two RAM stacks.
//
// Requests (insert, remove, read) are taken on req when start is high and
// busy is low. Each request gives exactly one response beat on rsp, marked
// by done for one cycle; the receiver cannot stall it.
// Before an insert or remove the gap travels to the edit point, one
// character per cycle (set by the left/right store ports), a distance
// of up to CAPACITY - 1. busy stays high until the response is posted;
// a new request may start in the done cycle.
// Reset clears the counts (empty text); store contents need no clearing.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core #(
    parameter int CAPACITY = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output      logic           busy,
    input  wire gbts_pkg::req_t req,
    output      logic           done,
    output      gbts_pkg::rsp_t rsp
);

    gbts_pkg::gbts_cmd_t  cmd;
    gbts_pkg::gbts_stat_t stat;

    // request sequencer
    gbts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // stores and counters
    gbts_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

// File: tb/gap_buffer_text_store_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core_test
// Self-checking bench for the gap buffer text store. A directed opening hits
// empty, unused-kind and out-of-range requests and edits at both ends of the text.
// A long random run then fills the store until it is full and mixes edits.
// A scoreboard keeps its own gap buffer image and checks every response
// beat against it.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core_test;

    localparam int         TEXT_CAPACITY = 256;
    localparam int         RANDOM_ITEMS  = 400;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    typedef enum int {
        PH_FILL,
        PH_FULL_PROBE,
        PH_MIXED
    } run_phase_t;

    // scoreboard with its own gap buffer image of the text
    class text_store_scoreboard;
        logic [7:0]      left_mem [0:TEXT_CAPACITY-1];
        logic [7:0]      right_mem [0:TEXT_CAPACITY-1];
        int unsigned     left_n;
        int unsigned     right_n;
        int unsigned     length;
        int unsigned     peak_length;
        gbts_pkg::rsp_t  expected_rsp_q[$];
        int              errors;
        int              requests;
        int              responses;
        int              status_seen[4];

        function new();
            left_n      = 0;
            right_n     = 0;
            length      = 0;
            peak_length = 0;
            errors      = 0;
            requests    = 0;
            responses   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int unsigned text_len();
            return length;
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction

        // walk the gap one character at a time until left_n reaches target
        function void move_gap_to(int unsigned target);
            while (left_n != target)
            begin
                if (left_n > target)
                begin
                    right_mem[right_n] = left_mem[left_n - 1];
                    right_n++;
                    left_n--;
                end
                else
                begin
                    left_mem[left_n] = right_mem[right_n - 1];
                    left_n++;
                    right_n--;
                end
            end
        endfunction

        // predict the response of an accepted request beat
        function void note_request(gbts_pkg::req_t r);
            gbts_pkg::rsp_t want;
            int unsigned    pos;
            int unsigned    off;
            want = '0;
            pos  = r.position;
            case (r.kind)
                gbts_pkg::KIND_INSERT:
                begin
                    if (length >= TEXT_CAPACITY - 1)
                        want.status = gbts_pkg::ST_FULL;
                    else if (pos > length)
                        want.status = gbts_pkg::ST_RANGE;
                    else
                    begin
                        move_gap_to(pos);
                        left_mem[left_n] = r.char_in;
                        left_n++;
                        length++;
                    end
                end
                gbts_pkg::KIND_REMOVE:
                begin
                    if (length == 0)
                        want.status = gbts_pkg::ST_EMPTY;
                    else if (pos >= length)
                        want.status = gbts_pkg::ST_RANGE;
                    else
                    begin
                        move_gap_to(pos + 1);
                        want.char_out = left_mem[left_n - 1];
                        left_n--;
                        length--;
                    end
                end
                gbts_pkg::KIND_READ:
                begin
                    if (pos >= length)
                        want.status = gbts_pkg::ST_RANGE;
                    else if (pos < left_n)
                        want.char_out = left_mem[pos];
                    else
                    begin
                        off = pos - left_n;
                        want.char_out = right_mem[right_n - 1 - off];
                    end
                end
                default:
                    want.status = gbts_pkg::ST_RANGE;
            endcase
            want.char_count = 8'(length);
            if (length > peak_length)
                peak_length = length;
            requests++;
            expected_rsp_q.push_back(want);
        endfunction

        // compare one response beat with the oldest prediction
        function void check_response(gbts_pkg::rsp_t got);
            gbts_pkg::rsp_t want;
            if (expected_rsp_q.size() == 0)
            begin
                $error("response beat with no request waiting: %0d 0x%02h %0d",
                       got.status, got.char_out, got.char_count);
                errors++;
                return;
            end
            want = expected_rsp_q.pop_front();
            responses++;
            status_seen[got.status]++;
            if (got.status !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.char_out !== want.char_out)
            begin
                $error("char_out mismatch: expected 0x%02h, actual 0x%02h",
                       want.char_out, got.char_out);
                errors++;
            end
            if (got.char_count !== want.char_count)
            begin
                $error("char_count mismatch: expected %0d, actual %0d",
                       want.char_count, got.char_count);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    gbts_pkg::req_t req;
    logic           done;
    gbts_pkg::rsp_t rsp;

    text_store_scoreboard text_sb;
    int                   no_idle_left;

    gap_buffer_text_store_core #(
        .CAPACITY(TEXT_CAPACITY)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            text_sb.check_response(rsp);
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic gbts_pkg::req_t make_req(logic [1:0] k, logic [7:0] p,
                                                logic [7:0] c);
        gbts_pkg::req_t r;
        r.kind     = k;
        r.position = p;
        r.char_in  = c;
        return r;
    endfunction

    // in-range position for this kind and length; any if not insert and empty
    function automatic logic [7:0] legal_position(logic [1:0] k, int unsigned len);
        if (k == gbts_pkg::KIND_INSERT)
            return 8'($urandom_range(0, len));
        if (len == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, len - 1));
    endfunction

    function automatic gbts_pkg::req_t noise_req();
        return make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endfunction

    // idle cycles ahead of the next beat, with bursts of back to back beats
    function automatic int draw_gap();
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            no_idle_left = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // present one request beat and wait for it to be taken
    task automatic send_request(input gbts_pkg::req_t r);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        req   = r;
        do
            @(posedge clk);
        while (busy);
        text_sb.note_request(r);
    endtask

    // hold off until every predicted response has come back
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        do
            @(posedge clk);
        while (text_sb.pending() > 0);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        int unsigned    len;
        int             roll;
        int             probe_left;
        run_phase_t     phase;
        logic [1:0]     k;
        gbts_pkg::req_t r;

        text_sb      = new();
        no_idle_left = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, unused kind, edits at both ends and the middle
        send_request(make_req(gbts_pkg::KIND_READ,   8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd255, 8'hFF));
        send_request(make_req(KIND_UNUSED,           8'd255, 8'hFF));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd1,   8'h11));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd1,   8'hFF));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd0,   8'hA5));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd1,   8'h5A));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd0,   8'hFF));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd1,   8'h00));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd2,   8'h00));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd3,   8'h00));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd4,   8'h00));
        send_request(make_req(gbts_pkg::KIND_READ,   8'd255, 8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd4,   8'h00));
        send_request(make_req(gbts_pkg::KIND_INSERT, 8'd255, 8'hFF));
        send_request(make_req(KIND_UNUSED,           8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd3,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd1,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd0,   8'h00));
        send_request(make_req(gbts_pkg::KIND_REMOVE, 8'd0,   8'h00));
        wait_drained();

        // random: fill until full, probe the full store, then mixed edits
        phase      = PH_FILL;
        probe_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            len  = text_sb.text_len();
            roll = $urandom_range(0, 99);
            if (phase == PH_FILL && len >= TEXT_CAPACITY - 1)
            begin
                phase      = PH_FULL_PROBE;
                probe_left = 8;
            end
            case (phase)
                PH_FILL:
                begin
                    if (roll < 88)
                        k = gbts_pkg::KIND_INSERT;
                    else if (roll < 92)
                        k = gbts_pkg::KIND_REMOVE;
                    else
                        k = gbts_pkg::KIND_READ;
                    if (roll < 96)
                        r = make_req(k, legal_position(k, len), 8'($urandom_range(0, 255)));
                    else
                        r = noise_req();
                end
                PH_FULL_PROBE:
                begin
                    if (roll < 75)
                        r = make_req(gbts_pkg::KIND_INSERT, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
                    else
                        r = make_req(gbts_pkg::KIND_READ,
                                     legal_position(gbts_pkg::KIND_READ, len), 8'h00);
                end
                default:
                begin
                    if (roll < 35)
                        k = gbts_pkg::KIND_INSERT;
                    else if (roll < 70)
                        k = gbts_pkg::KIND_REMOVE;
                    else
                        k = gbts_pkg::KIND_READ;
                    if (roll < 90)
                        r = make_req(k, legal_position(k, len), 8'($urandom_range(0, 255)));
                    else
                        r = noise_req();
                end
            endcase
            send_request(r);
            if (phase == PH_FULL_PROBE)
            begin
                probe_left--;
                if (probe_left == 0)
                begin
                    wait_drained();
                    phase = PH_MIXED;
                end
            end
        end

        // drain and let the block settle
        wait_drained();
        repeat (16) @(posedge clk);

        $display("run covered %0d requests and %0d responses, peak text length %0d",
                 text_sb.requests, text_sb.responses, text_sb.peak_length);
        $display("responses by status: ok %0d, full %0d, range %0d, empty %0d",
                 text_sb.status_seen[gbts_pkg::ST_OK],
                 text_sb.status_seen[gbts_pkg::ST_FULL],
                 text_sb.status_seen[gbts_pkg::ST_RANGE],
                 text_sb.status_seen[gbts_pkg::ST_EMPTY]);
        if (text_sb.errors == 0 && text_sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
src/gbts_pkg.sv
src/gbts_ram.sv
src/gbts_ctrl.sv
src/gbts_datapath.sv
src/gap_buffer_text_store_core.sv
tb/gap_buffer_text_store_core_test.sv
